[rtl/ihe_pkg.sv]
// ----------------------------------------------------------------------------
// ihe_pkg
// Shared widths, request codes and reset values of the intensity histogram
// engine.
// ----------------------------------------------------------------------------
package ihe_pkg;

	// histogram geometry
	localparam int NUM_BINS   = 256;
	localparam int BIN_BITS   = $clog2(NUM_BINS);
	localparam int COUNT_BITS = 24;

	// word field widths
	localparam int REQ_BITS   = 2;
	localparam int PIX_BITS   = 8;
	localparam int SCALE_BITS = 12;
	localparam int PROD_BITS  = SCALE_BITS + COUNT_BITS;

	// request codes
	localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_ADD   = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd2;

	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 12'd300;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [BIN_BITS-1:0]   bin_addr_t;

endpackage

[rtl/ihe_ifs.sv]
// ----------------------------------------------------------------------------
// ihe channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel: one word per clear, add or read
interface ihe_req_if;
	import ihe_pkg::*;
	logic                valid;
	logic                ready;
	logic [REQ_BITS-1:0] req_type;
	logic [PIX_BITS-1:0] pixel_value;
	logic [PIX_BITS-1:0] bin_index;

	modport source (output valid, req_type, pixel_value, bin_index, input ready);
	modport sink   (input valid, req_type, pixel_value, bin_index, output ready);
endinterface

// response channel: one word per read
interface ihe_rsp_if;
	import ihe_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] bin_count;
	logic [COUNT_BITS-1:0] max_count;
	logic [SCALE_BITS-1:0] bar_height;

	modport source (output valid, bin_count, max_count, bar_height, input ready);
	modport sink   (input valid, bin_count, max_count, bar_height, output ready);
endinterface

// configuration channel: bar_scale write data
interface ihe_cfg_if;
	import ihe_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [SCALE_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/intensity_histogram_engine.sv]
// ----------------------------------------------------------------------------
// intensity_histogram_engine
// 256-bin pixel histogram with running maximum and scaled bar readout.
// ----------------------------------------------------------------------------
// Adds and clears are taken at one word per cycle while no read is in
// progress: bin counts live in a single-port-write RAM with a registered
// read, and back-to-back adds to the same bin are forwarded from the previous
// write. A clear drops all per-bin valid bits together, so it costs no sweep.
// A read holds off the request channel until its result is in the response
// register: the multiply in stage 1, then the shift-subtract divider, one
// quotient bit per cycle, then the response register. Adds and clears
// continue while a finished response waits to be taken.
module intensity_histogram_engine (
	input  logic        clk,
	input  logic        arst_n,
	ihe_req_if.sink     req,
	ihe_rsp_if.source   rsp,
	ihe_cfg_if.sink     cfg
);
	import ihe_pkg::*;

	localparam int STEP_BITS = $clog2(SCALE_BITS + 1);
	localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(SCALE_BITS);

	// configuration
	logic [SCALE_BITS-1:0] scale_q;

	// stage 1 (word accepted, RAM data arrives)
	logic                valid_s1;
	logic [REQ_BITS-1:0] req_s1;
	bin_addr_t           addr_s1;
	logic                inrange_s1;

	// bin storage
	count_t              mem [NUM_BINS];
	count_t              rd_q;
	logic [NUM_BINS-1:0] bin_vld_q;
	count_t              max_q;

	// forwarding of the last write
	logic      fwd_en_q;
	bin_addr_t fwd_addr_q;
	count_t    fwd_data_q;

	// divider
	logic                  div_busy_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [PROD_BITS-1:0]  work_q;
	count_t                res_cnt_q;
	count_t                res_max_q;

	// response register
	logic                  out_vld_q;
	count_t                out_cnt_q;
	count_t                out_max_q;
	logic [SCALE_BITS-1:0] out_bar_q;

	logic                 accept;
	logic [PIX_BITS-1:0]  in_addr;
	logic                 in_range;
	count_t               base_cnt;
	count_t               cur_cnt;
	count_t               inc_cnt;
	logic                 wr_en;
	logic                 clr;
	logic                 rd_start;
	logic                 div_done;
	logic                 out_free;
	logic [COUNT_BITS:0]  div_sh;
	logic [COUNT_BITS:0]  div_diff;
	logic                 div_ge;
	count_t               div_rem;

	// handshakes
	assign req.ready = !div_busy_q && !(valid_s1 && req_s1 == REQ_READ);
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;

	// address of the incoming word: pixel for adds, bin index otherwise
	assign in_addr  = (req.req_type == REQ_ADD) ? req.pixel_value : req.bin_index;
	assign in_range = ({1'b0, in_addr} < (PIX_BITS + 1)'(NUM_BINS));

	// current count of the stage 1 bin, with forwarding and valid bits
	always_comb begin
		if (fwd_en_q && fwd_addr_q == addr_s1)
			base_cnt = fwd_data_q;
		else if (bin_vld_q[addr_s1])
			base_cnt = rd_q;
		else
			base_cnt = '0;
		cur_cnt = inrange_s1 ? base_cnt : '0;
		inc_cnt = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + 1'b1;
	end

	assign wr_en    = valid_s1 && req_s1 == REQ_ADD && inrange_s1;
	assign clr      = valid_s1 && req_s1 == REQ_CLEAR;
	assign rd_start = valid_s1 && req_s1 == REQ_READ;

	// one restoring divide step: remainder stays below the maximum
	assign div_sh   = {work_q[PROD_BITS-1:SCALE_BITS], work_q[SCALE_BITS-1]};
	assign div_diff = div_sh - {1'b0, res_max_q};
	assign div_ge   = (div_sh >= {1'b0, res_max_q});
	assign div_rem  = div_ge ? div_diff[COUNT_BITS-1:0] : div_sh[COUNT_BITS-1:0];
	assign div_done = div_busy_q && step_q == DIV_LAST;

	// bin RAM: write-back of adds, read of the incoming address
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_s1] <= inc_cnt;
		rd_q <= mem[in_addr[BIN_BITS-1:0]];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= SCALE_RESET;
		else if (cfg.valid && cfg.ready)
			scale_q <= cfg.data;
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		req_s1     <= req.req_type;
		addr_s1    <= in_addr[BIN_BITS-1:0];
		inrange_s1 <= in_range;
	end

	// valid bits, running maximum, forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			max_q     <= '0;
			fwd_en_q  <= 1'b0;
		end else begin
			fwd_en_q <= wr_en;
			if (clr) begin
				bin_vld_q <= '0;
				max_q     <= '0;
			end else if (wr_en) begin
				bin_vld_q[addr_s1] <= 1'b1;
				if (inc_cnt > max_q)
					max_q <= inc_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= inc_cnt;
	end

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			step_q     <= '0;
		end else if (rd_start) begin
			div_busy_q <= 1'b1;
			step_q     <= '0;
		end else if (div_done) begin
			if (out_free)
				div_busy_q <= 1'b0;
		end else if (div_busy_q) begin
			step_q <= step_q + 1'b1;
		end
	end

	// divider datapath: product loaded in stage 1, then one bit per cycle
	always_ff @(posedge clk) begin
		if (rd_start) begin
			work_q    <= PROD_BITS'(scale_q) * PROD_BITS'(cur_cnt);
			res_cnt_q <= cur_cnt;
			res_max_q <= max_q;
		end else if (div_busy_q && !div_done) begin
			work_q <= {div_rem, work_q[SCALE_BITS-2:0], div_ge};
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (div_done && out_free)
			out_vld_q <= 1'b1;
		else if (rsp.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (div_done && out_free) begin
			out_cnt_q <= res_cnt_q;
			out_max_q <= res_max_q;
			out_bar_q <= (res_max_q == '0) ? '0 : work_q[SCALE_BITS-1:0];
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.bin_count  = out_cnt_q;
	assign rsp.max_count  = out_max_q;
	assign rsp.bar_height = out_bar_q;

	// a bin never exceeds the running maximum
	a_cnt_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.bin_count <= rsp.max_count)
		else $error("bin count above maximum");

	// the bar never exceeds full scale
	a_bar_le_scale: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.bar_height <= scale_q)
		else $error("bar height above scale");

	// consecutive writes to one bin never go backwards (forwarding check)
	a_fwd_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && fwd_en_q && addr_s1 == fwd_addr_q) |-> inc_cnt >= fwd_data_q)
		else $error("forwarded count lost");

	// the maximum only drops on a clear
	a_max_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(max_q < $past(max_q)) |-> $past(clr))
		else $error("maximum dropped without clear");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the intensity histogram engine. A scoreboard class
// keeps its own copy of the bins, the running maximum and bar_scale, works out
// the response to each read word and compares it field by field with what
// the engine returns. Directed words hit the field extremes, every request
// code and the cleared and empty cases. Random bursts of adds and reads, with
// clears and noise words, then run under several bar_scale settings, with
// random gaps and stalls on both channels (one phase sends without gaps).
// ----------------------------------------------------------------------------
module tb_top;
	import ihe_pkg::*;

	// request code the engine must ignore
	localparam logic [REQ_BITS-1:0] REQ_IGNORED = 2'd3;

	localparam int DRAIN_CYCLES  = 24;
	localparam int LONG_HOLD     = 400;   // one long response stall
	localparam int WATCHDOG_IDLE = 4000;  // cycles with no handshake at all
	localparam int PHASE_WORDS   = 230;

	typedef struct packed {
		count_t                cnt;
		count_t                peak;
		logic [SCALE_BITS-1:0] bar;
	} bin_report_t;

	// ------------------------------------------------------------------------
	// histogram predictor and store of expected read responses
	// ------------------------------------------------------------------------
	class histogram_scoreboard;
		count_t                hist [NUM_BINS];
		count_t                peak;
		logic [SCALE_BITS-1:0] scale;
		bin_report_t           pending_reports [$];
		int                    errors;
		int                    n_add, n_read, n_clear, n_ignored, n_checked, n_cfg;

		function new();
			wipe();
			scale = SCALE_RESET;
		endfunction

		function void wipe();
			foreach (hist[k])
				hist[k] = '0;
			peak = '0;
		endfunction

		function void set_scale(logic [SCALE_BITS-1:0] v);
			scale = v;
			n_cfg++;
		endfunction

		// apply one accepted request word
		function void note_word(logic [REQ_BITS-1:0] rt, logic [PIX_BITS-1:0] pix,
				logic [PIX_BITS-1:0] idx);
			count_t                c;
			logic [PROD_BITS-1:0]  prod;
			bin_report_t           r;
			case (rt)
				REQ_CLEAR: begin
					wipe();
					n_clear++;
				end
				REQ_ADD: begin
					if (int'(pix) < NUM_BINS) begin
						c = hist[pix];
						if (c != COUNT_MAX)
							c = c + 1'b1;   // saturates at the count width
						hist[pix] = c;
						if (c > peak)
							peak = c;
					end
					n_add++;
				end
				REQ_READ: begin
					c = (int'(idx) < NUM_BINS) ? hist[idx] : '0;
					r.cnt  = c;
					r.peak = peak;
					if (peak == '0) begin
						r.bar = '0;
					end else begin
						prod  = PROD_BITS'(scale) * PROD_BITS'(c);
						r.bar = SCALE_BITS'(prod / PROD_BITS'(peak));
					end
					pending_reports.push_back(r);
					n_read++;
				end
				default: n_ignored++;
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted response word with the oldest expectation
		function void check_report(count_t cnt, count_t pk, logic [SCALE_BITS-1:0] bar);
			bin_report_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
					$time, cnt, pk, bar);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				compare_field("bin_count", 32'(want.cnt), 32'(cnt));
				compare_field("max_count", 32'(want.peak), 32'(pk));
				compare_field("bar_height", 32'(want.bar), 32'(bar));
				n_checked++;
			end
		endfunction

		function int outstanding();
			return pending_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ihe_req_if req_ch ();
	ihe_rsp_if rsp_ch ();
	ihe_cfg_if cfg_ch ();

	histogram_scoreboard sb = new();

	bit calm;           // sender runs without gaps
	bit hold_request;   // asks the response side for one long stall
	int held_cycles;
	int idle_cycles;

	intensity_histogram_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// monitors: every handshake on the three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_word(req_ch.req_type, req_ch.pixel_value, req_ch.bin_index);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_report(rsp_ch.bin_count, rsp_ch.max_count, rsp_ch.bar_height);
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_scale(cfg_ch.data);
		end
	end

	// watchdog: too long with no word moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_IDLE) begin
				$display("%0t: timeout, %0d responses still expected", $time, sb.outstanding());
				$display("FAIL intensity_histogram_engine");
				$finish;
			end
		end
	end

	// response side: ready stretches, random stalls, one long hold on request
	initial begin : rsp_sink
		int run;
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				held_cycles = LONG_HOLD;
			end
			run = $urandom_range(1, 40);
			rsp_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = gap_len();
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// offer one request word and hold it until taken
	task automatic send_word(input logic [REQ_BITS-1:0] rt, input logic [PIX_BITS-1:0] pix,
			input logic [PIX_BITS-1:0] idx);
		int gap;
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= rt;
		req_ch.pixel_value <= pix;
		req_ch.bin_index   <= idx;
		do @(posedge clk); while (!req_ch.ready);
		gap = calm ? 0 : gap_len();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait for every expected response
	task automatic wait_drained(input int settle);
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// bar_scale write, only with the engine idle
	task automatic write_scale(input logic [SCALE_BITS-1:0] v);
		wait_drained(DRAIN_CYCLES);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// random phase: add bursts on a few hot bins with reads, plus noise words
	task automatic run_phase(input int n_words, input bit calm_phase);
		int                  sent;
		int                  nadd;
		int                  nread;
		int                  nnoise;
		bit                  paused;
		logic [PIX_BITS-1:0] hot [4];
		logic [PIX_BITS-1:0] pix;
		logic [PIX_BITS-1:0] idx;
		logic [REQ_BITS-1:0] rt;
		calm   = calm_phase;
		sent   = 0;
		paused = 1'b0;
		foreach (hot[k])
			hot[k] = PIX_BITS'($urandom_range(0, 255));
		while (sent < n_words) begin
			// once per phase the sender waits for all responses
			if (!paused && sent >= n_words / 2) begin
				paused = 1'b1;
				wait_drained(0);
			end
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 3) == 0)
					hot[2'($urandom_range(0, 3))] = PIX_BITS'($urandom_range(0, 255));
				if ($urandom_range(0, 9) == 0) begin
					send_word(REQ_CLEAR, PIX_BITS'($urandom_range(0, 255)),
						PIX_BITS'($urandom_range(0, 255)));
					sent++;
				end
				nadd = $urandom_range(4, 40);
				repeat (nadd) begin
					pix = ($urandom_range(0, 3) != 0) ? hot[2'($urandom_range(0, 3))]
						: PIX_BITS'($urandom_range(0, 255));
					send_word(REQ_ADD, pix, PIX_BITS'($urandom_range(0, 255)));
				end
				nread = $urandom_range(1, 5);
				repeat (nread) begin
					idx = ($urandom_range(0, 9) < 7) ? hot[2'($urandom_range(0, 3))]
						: PIX_BITS'($urandom_range(0, 255));
					send_word(REQ_READ, PIX_BITS'($urandom_range(0, 255)), idx);
				end
				sent += nadd + nread;
			end else begin
				// noise: any code, any fields; clears kept rarer
				nnoise = $urandom_range(1, 6);
				repeat (nnoise) begin
					rt = REQ_BITS'($urandom_range(0, 3));
					if (rt == REQ_CLEAR && $urandom_range(0, 2) != 0)
						rt = REQ_IGNORED;
					send_word(rt, PIX_BITS'($urandom_range(0, 255)),
						PIX_BITS'($urandom_range(0, 255)));
					if (rt != REQ_IGNORED)
						sent++;
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin : stimulus
		logic [SCALE_BITS-1:0] scales [6];
		scales = '{12'd4095, 12'd1, 12'd0, SCALE_BITS'($urandom_range(2, 4094)),
			SCALE_RESET, SCALE_BITS'($urandom_range(2, 4094))};
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_CLEAR;
		req_ch.pixel_value = '0;
		req_ch.bin_index   = '0;
		rsp_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty histogram reads, extremes, repeated adds to one bin
		send_word(REQ_READ, 8'h00, 8'h00);
		send_word(REQ_READ, 8'hFF, 8'hFF);
		send_word(REQ_ADD, 8'h00, 8'hFF);
		send_word(REQ_ADD, 8'hFF, 8'h00);
		send_word(REQ_ADD, 8'hFF, 8'h00);
		send_word(REQ_ADD, 8'hFF, 8'h00);
		send_word(REQ_ADD, 8'h80, 8'h00);
		send_word(REQ_READ, 8'h00, 8'hFF);
		send_word(REQ_READ, 8'hFF, 8'h00);
		send_word(REQ_READ, 8'h00, 8'h80);
		send_word(REQ_READ, 8'h00, 8'h07);
		// unused code must leave the bins alone
		send_word(REQ_IGNORED, 8'h07, 8'h07);
		send_word(REQ_IGNORED, 8'hFF, 8'hFF);
		send_word(REQ_READ, 8'h00, 8'h07);
		send_word(REQ_ADD, 8'h55, 8'h00);
		send_word(REQ_ADD, 8'hAA, 8'h00);
		send_word(REQ_READ, 8'h00, 8'hAA);
		// clear, then read and add right behind it
		send_word(REQ_CLEAR, 8'hFF, 8'hFF);
		send_word(REQ_READ, 8'h00, 8'hFF);
		send_word(REQ_ADD, 8'h55, 8'hAA);
		send_word(REQ_READ, 8'hAA, 8'h55);
		send_word(REQ_READ, 8'hFF, 8'hAA);

		// random phases, one bar_scale setting each
		foreach (scales[p]) begin
			write_scale(scales[p]);
			if (p == 1)
				hold_request = 1'b1;
			run_phase(PHASE_WORDS, p == 3);
		end
		wait_drained(DRAIN_CYCLES);

		$display("Covered %0d adds, %0d reads, %0d clears, %0d ignored words over %0d scale writes",
			sb.n_add, sb.n_read, sb.n_clear, sb.n_ignored, sb.n_cfg);
		$display("%0d responses checked, one response stall of %0d cycles",
			sb.n_checked, held_cycles);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("PASS intensity_histogram_engine");
		end else begin
			$display("FAIL intensity_histogram_engine");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/ihe_pkg.sv
rtl/ihe_ifs.sv
rtl/intensity_histogram_engine.sv
tb/tb_top.sv
